// ===== rtl/pik_pkg.sv =====
package pik_pkg;

  // field widths
  localparam int COORD_W   = 18;
  localparam int ANGLE_W   = 16;
  localparam int LINK_W    = 16;
  localparam int STATUS_W  = 2;
  localparam int REG_IDX_W = 2;

  // datapath widths
  localparam int ROT_W   = 36;  // tool vector, 2^-30 m
  localparam int WRIST_W = 22;  // wrist point, 2^-16 m
  localparam int SUM_W   = 44;  // squared distances
  localparam int NORM_W  = 32;  // normalized law-of-cosines terms
  localparam int VIN_W   = 34;  // vectoring operand in
  localparam int VEC_W   = 44;  // vectoring datapath
  localparam int TAB_LEN = 24;

  // inverse cordic gain, q31
  localparam logic [30:0] INV_GAIN = 31'd1304065748;

  localparam logic [LINK_W-1:0] UPPER_RESET = 16'd16384;
  localparam logic [LINK_W-1:0] FORE_RESET  = 16'd16384;
  localparam logic [LINK_W-1:0] TOOL_RESET  = 16'd4096;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_UPPER = 2'd0,
    REG_FORE  = 2'd1,
    REG_TOOL  = 2'd2
  } reg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_SOLVED        = 2'd0,
    ST_OUT_OF_REACH  = 2'd1,
    ST_WRIST_AT_BASE = 2'd2
  } status_t;

  // arctangent of 2^-i, 2^32 per turn
  localparam logic [31:0] ATAN_TAB [0:TAB_LEN-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85005268, 32'd42667331,
    32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  // table entry rounded to the angle resolution, in units of that resolution
  function automatic logic [31:0] atan_q(input int idx, input int abits);
    logic [31:0] unit;
    unit = 32'd1 << (32 - abits);
    return ((ATAN_TAB[idx] + (unit >> 1)) & ~(unit - 32'd1)) >> (32 - abits);
  endfunction

  // index of the highest set bit
  function automatic logic [5:0] msb_index(input logic [SUM_W-1:0] v);
    logic [5:0] pos;
    pos = '0;
    for (int i = 0; i < SUM_W; i++) begin
      if (v[i]) pos = 6'(i);
    end
    return pos;
  endfunction

endpackage

// ===== rtl/pik_if.sv =====
interface pik_target_if;
  logic valid;
  logic ready;
  logic signed [pik_pkg::COORD_W-1:0] target_x;
  logic signed [pik_pkg::COORD_W-1:0] target_y;
  logic signed [pik_pkg::ANGLE_W-1:0] tool_angle;
  modport source (output valid, target_x, target_y, tool_angle, input ready);
  modport sink (input valid, target_x, target_y, tool_angle, output ready);
endinterface

interface pik_joint_if;
  logic valid;
  logic ready;
  logic signed [pik_pkg::ANGLE_W-1:0] shoulder_angle;
  logic signed [pik_pkg::ANGLE_W-1:0] elbow_angle;
  logic signed [pik_pkg::ANGLE_W-1:0] wrist_angle;
  logic [pik_pkg::STATUS_W-1:0] solve_status;
  modport source (output valid, shoulder_angle, elbow_angle, wrist_angle, solve_status,
                  input ready);
  modport sink (input valid, shoulder_angle, elbow_angle, wrist_angle, solve_status,
                output ready);
endinterface

interface pik_cfg_if;
  logic valid;
  logic ready;
  logic [pik_pkg::REG_IDX_W-1:0] index;
  logic [pik_pkg::LINK_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/planar_three_link_inverse_kinematics_top.sv =====
// Inverse kinematics of a planar arm with three revolute joints.
// target channel: one beat carries target_x, target_y (2^-14 m) and the tool
// angle (65536 counts per turn). joints channel: one beat carries shoulder,
// elbow and wrist angles and solve_status (solved, out of reach, wrist at base);
// when not solved all three angles are zero.
// cfg channel: writes the three link lengths by register index, always ready;
// index 3 is ignored. Write only while no target beat is in flight.
// Throughput: one target beat per cycle while no stall on joints holds the pipeline.
// From target accept to joints valid a beat passes the rotation cordic, the 32-step
// square root and the vectoring cordics in series.
// A stall on joints holds the full pipeline only when its last stage holds a
// beat; until then target keeps being accepted and bubbles are squeezed out.
// Reset empties the pipeline and loads the default link lengths.
module planar_three_link_inverse_kinematics_top #(
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic         clk,
  input  logic         rst,
  pik_target_if.sink   target,
  pik_joint_if.source  joints,
  pik_cfg_if.sink      cfg
);

  localparam int AB = ANGLE_BITS;
  localparam int CS = CORDIC_STAGES;
  localparam int VW = pik_pkg::ROT_W;
  localparam int WX = VW + 1;
  localparam int NW = pik_pkg::WRIST_W;
  localparam int DW = pik_pkg::SUM_W;
  localparam int SW = pik_pkg::NORM_W;
  localparam int IW = pik_pkg::VIN_W;
  localparam int CW = pik_pkg::COORD_W;
  localparam int LW = pik_pkg::LINK_W;
  localparam logic [31:0] PHI_HALF = 32'd1 << (31 - AB);

  typedef struct packed {
    logic [pik_pkg::STATUS_W-1:0] stat;
    logic [AB-1:0]                phi;
    logic signed [NW-1:0]         nx;
    logic signed [NW-1:0]         ny;
  } side_t;

  localparam int TW = $bits(side_t) + 2 * SW;
  localparam int ET = pik_pkg::STATUS_W + AB;

  // link length registers
  logic [LW-1:0] upper_len, fore_len, tool_len;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_len <= pik_pkg::UPPER_RESET;
      fore_len  <= pik_pkg::FORE_RESET;
      tool_len  <= pik_pkg::TOOL_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        pik_pkg::REG_UPPER: upper_len <= cfg.data;
        pik_pkg::REG_FORE:  fore_len  <= cfg.data;
        pik_pkg::REG_TOOL:  tool_len  <= cfg.data;
        default: ;
      endcase
    end
  end

  // pipeline advance: hold only when the last stage cannot drain
  logic adv;
  logic out_valid;
  logic vec_valid;

  assign adv          = !(out_valid && !joints.ready && vec_valid);
  assign target.ready = adv;

  // input stage: tool vector and quadrant fold
  logic [46:0]          tool_prod;
  logic signed [VW-1:0] tool_vec;
  logic [31:0]          phi_full;
  logic [AB-1:0]        phi_q;
  logic                 flip;

  assign tool_prod = 47'(tool_len) * 47'(pik_pkg::INV_GAIN);
  assign tool_vec  = $signed(VW'(tool_prod >> 15));
  assign phi_full  = {target.tool_angle, 16'b0} + PHI_HALF;
  assign phi_q     = phi_full[31 -: AB];
  assign flip      = phi_q[AB-1] ^ phi_q[AB-2];

  logic signed [VW-1:0] rvx  [0:CS];
  logic signed [VW-1:0] rvy  [0:CS];
  logic [AB-1:0]        rz   [0:CS];
  logic signed [CW-1:0] rtx  [0:CS];
  logic signed [CW-1:0] rty  [0:CS];
  logic [AB-1:0]        rphi [0:CS];
  logic                 rv   [0:CS];

  always_ff @(posedge clk) begin
    if (adv) begin
      rvx[0]  <= flip ? -tool_vec : tool_vec;
      rvy[0]  <= '0;
      rz[0]   <= flip ? {~phi_q[AB-1], phi_q[AB-2:0]} : phi_q;
      rtx[0]  <= target.target_x;
      rty[0]  <= target.target_y;
      rphi[0] <= phi_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv[0] <= 1'b0;
    end else if (adv) begin
      rv[0] <= target.valid;
    end
  end

  // rotation cordic turns the tool vector by the tool angle
  for (genvar i = 0; i < CS; i++) begin : g_rot
    localparam logic [AB-1:0] A = AB'(pik_pkg::atan_q(i, AB));

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!rz[i][AB-1]) begin
          rvx[i+1] <= rvx[i] - (rvy[i] >>> i);
          rvy[i+1] <= rvy[i] + (rvx[i] >>> i);
          rz[i+1]  <= rz[i] - A;
        end else begin
          rvx[i+1] <= rvx[i] + (rvy[i] >>> i);
          rvy[i+1] <= rvy[i] - (rvx[i] >>> i);
          rz[i+1]  <= rz[i] + A;
        end
        rtx[i+1]  <= rtx[i];
        rty[i+1]  <= rty[i];
        rphi[i+1] <= rphi[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        rv[i+1] <= 1'b0;
      end else if (adv) begin
        rv[i+1] <= rv[i];
      end
    end
  end

  // wrist point
  logic signed [WX-1:0] wsx, wsy;
  side_t                wside;
  logic                 wv;

  assign wsx = WX'($signed({rtx[CS], 16'b0})) - WX'(rvx[CS]) + WX'(8192);
  assign wsy = WX'($signed({rty[CS], 16'b0})) - WX'(rvy[CS]) + WX'(8192);

  always_ff @(posedge clk) begin
    if (adv) begin
      wside.stat <= pik_pkg::ST_SOLVED;
      wside.phi  <= rphi[CS];
      wside.nx   <= NW'(wsx >>> 14);
      wside.ny   <= NW'(wsy >>> 14);
    end
  end

  // squares and link products
  logic [17:0]          l1, l2;
  logic signed [DW-1:0] mxx, myy, m11, m22, m12;
  side_t                mside;
  logic                 mv;

  assign l1 = {upper_len, 2'b00};
  assign l2 = {fore_len, 2'b00};

  always_ff @(posedge clk) begin
    if (adv) begin
      mxx   <= DW'(wside.nx) * DW'(wside.nx);
      myy   <= DW'(wside.ny) * DW'(wside.ny);
      m11   <= $signed(DW'(l1) * DW'(l1));
      m22   <= $signed(DW'(l2) * DW'(l2));
      m12   <= $signed(DW'(l1) * DW'(l2));
      mside <= wside;
    end
  end

  // law of cosines terms
  logic signed [DW-1:0] nd, nnum, nden, np;
  side_t                nside;
  logic                 nv;

  always_ff @(posedge clk) begin
    if (adv) begin
      nd    <= mxx + myy;
      nnum  <= mxx + myy - m11 - m22;
      nden  <= m12 <<< 1;
      np    <= mxx + myy + m11 - m22;
      nside <= mside;
    end
  end

  // reach check and shoulder normalizer
  logic signed [DW-1:0] abs_num, abs_p;
  logic signed [DW-1:0] fnum, fden, fp, fm2;
  side_t                fside;
  logic                 fv;

  assign abs_num = nnum[DW-1] ? -nnum : nnum;
  assign abs_p   = np[DW-1] ? -np : np;

  always_ff @(posedge clk) begin
    if (adv) begin
      fnum  <= nnum;
      fden  <= nden;
      fp    <= np;
      fm2   <= (nden > abs_p) ? nden : abs_p;
      fside <= nside;
      if (nden == '0 || abs_num > nden) begin
        fside.stat <= pik_pkg::ST_OUT_OF_REACH;
      end else if (nd == '0) begin
        fside.stat <= pik_pkg::ST_WRIST_AT_BASE;
      end else begin
        fside.stat <= pik_pkg::ST_SOLVED;
      end
    end
  end

  // leading one positions
  logic [5:0]           gpos1, gpos2;
  logic signed [DW-1:0] gnum, gden, gp;
  side_t                gside;
  logic                 gv;

  always_ff @(posedge clk) begin
    if (adv) begin
      gpos1 <= pik_pkg::msb_index(fden);
      gpos2 <= pik_pkg::msb_index(fm2);
      gnum  <= fnum;
      gden  <= fden;
      gp    <= fp;
      gside <= fside;
    end
  end

  // bring the reference term into [2^29, 2^30)
  function automatic logic signed [SW-1:0] norm_val(input logic signed [DW-1:0] v,
                                                    input logic [5:0] pos);
    logic signed [DW+23:0] t;
    logic [5:0]            amt;
    t   = $signed({v, 24'b0});
    amt = pos - 6'd5;
    return SW'(t >>> amt);
  endfunction

  logic signed [SW-1:0] hdn1, hnn1, hdn2, hnn2, hpp;
  side_t                hside;
  logic                 hv;

  always_ff @(posedge clk) begin
    if (adv) begin
      hdn1  <= norm_val(gden, gpos1);
      hnn1  <= norm_val(gnum, gpos1);
      hdn2  <= norm_val(gden, gpos2);
      hnn2  <= norm_val(gnum, gpos2);
      hpp   <= norm_val(gp, gpos2);
      hside <= gside;
    end
  end

  // clamp and difference of squares factors
  function automatic logic signed [SW-1:0] clamp(input logic signed [SW-1:0] v,
                                                 input logic signed [SW-1:0] lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  logic signed [SW-1:0] nc1, nc2;
  logic signed [SW-1:0] inn1, ipp;
  logic [31:0]          ia1, ib1, ia2, ib2;
  side_t                iside;
  logic                 iv;

  assign nc1 = clamp(hnn1, hdn1);
  assign nc2 = clamp(hnn2, hdn2);

  always_ff @(posedge clk) begin
    if (adv) begin
      ia1   <= 32'(hdn1 - nc1);
      ib1   <= 32'(hdn1 + nc1);
      ia2   <= 32'(hdn2 - nc2);
      ib2   <= 32'(hdn2 + nc2);
      inn1  <= nc1;
      ipp   <= hpp;
      iside <= hside;
    end
  end

  // radicands
  logic [63:0]          jr1, jr2;
  logic signed [SW-1:0] jnn, jpp;
  side_t                jside;
  logic                 jv;

  always_ff @(posedge clk) begin
    if (adv) begin
      jr1   <= 64'(ia1) * 64'(ib1);
      jr2   <= 64'(ia2) * 64'(ib2);
      jnn   <= inn1;
      jpp   <= ipp;
      jside <= iside;
    end
  end

  // valid bits of the middle stages
  always_ff @(posedge clk) begin
    if (rst) begin
      wv <= 1'b0;
      mv <= 1'b0;
      nv <= 1'b0;
      fv <= 1'b0;
      gv <= 1'b0;
      hv <= 1'b0;
      iv <= 1'b0;
      jv <= 1'b0;
    end else if (adv) begin
      wv <= rv[CS];
      mv <= wv;
      nv <= mv;
      fv <= nv;
      gv <= fv;
      hv <= gv;
      iv <= hv;
      jv <= iv;
    end
  end

  // square roots
  logic [31:0]          s1, s2;
  logic [TW-1:0]        q_tag;
  logic                 q_valid;
  side_t                qside;
  logic signed [SW-1:0] qnn, qpp;

  pik_isqrt #(.TAG_W(TW)) u_sqrt_elbow (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (jv),
    .in_rad    (jr1),
    .in_tag    ({jside, jnn, jpp}),
    .out_valid (q_valid),
    .out_root  (s1),
    .out_tag   (q_tag)
  );

  pik_isqrt #(.TAG_W(1)) u_sqrt_shoulder (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (jv),
    .in_rad    (jr2),
    .in_tag    (1'b0),
    .out_valid (),
    .out_root  (s2),
    .out_tag   ()
  );

  assign {qside, qnn, qpp} = q_tag;

  // elbow, wrist bearing and inner triangle angle
  logic [AB-1:0] e_ang, b_ang, i_ang;
  logic [ET-1:0] e_tag;
  logic [pik_pkg::STATUS_W-1:0] e_stat;
  logic [AB-1:0] e_phi;

  pik_vector #(.ANGLE_BITS(AB), .CORDIC_STAGES(CS), .TAG_W(ET)) u_vec_elbow (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (q_valid),
    .in_x      (IW'(qnn)),
    .in_y      ($signed({2'b00, s1})),
    .in_tag    ({qside.stat, qside.phi}),
    .out_valid (vec_valid),
    .out_angle (e_ang),
    .out_tag   (e_tag)
  );

  pik_vector #(.ANGLE_BITS(AB), .CORDIC_STAGES(CS), .TAG_W(1)) u_vec_bearing (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (q_valid),
    .in_x      (IW'(qside.nx)),
    .in_y      (IW'(qside.ny)),
    .in_tag    (1'b0),
    .out_valid (),
    .out_angle (b_ang),
    .out_tag   ()
  );

  pik_vector #(.ANGLE_BITS(AB), .CORDIC_STAGES(CS), .TAG_W(1)) u_vec_inner (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (q_valid),
    .in_x      (IW'(qpp)),
    .in_y      ($signed({2'b00, s2})),
    .in_tag    (1'b0),
    .out_valid (),
    .out_angle (i_ang),
    .out_tag   ()
  );

  assign {e_stat, e_phi} = e_tag;

  // joint angles and rounding to the output resolution
  function automatic logic [15:0] to_out(input logic [AB-1:0] a);
    logic [31:0] w;
    w = {a, {(32-AB){1'b0}}} + 32'h8000;
    return w[31:16];
  endfunction

  logic [AB-1:0] shoulder, wrist;

  assign shoulder = b_ang - i_ang;
  assign wrist    = e_phi - shoulder - e_ang;

  // output register
  logic [15:0]                  out_sh, out_el, out_wr;
  logic [pik_pkg::STATUS_W-1:0] out_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || joints.ready) begin
      out_valid <= vec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || joints.ready) begin
      out_st <= e_stat;
      if (e_stat == pik_pkg::ST_SOLVED) begin
        out_sh <= to_out(shoulder);
        out_el <= to_out(e_ang);
        out_wr <= to_out(wrist);
      end else begin
        out_sh <= '0;
        out_el <= '0;
        out_wr <= '0;
      end
    end
  end

  assign joints.valid          = out_valid;
  assign joints.shoulder_angle = out_sh;
  assign joints.elbow_angle    = out_el;
  assign joints.wrist_angle    = out_wr;
  assign joints.solve_status   = out_st;

  // unsolved beats carry zero angles
  assert property (@(posedge clk) disable iff (rst)
    (joints.valid && joints.solve_status != pik_pkg::ST_SOLVED) |->
      (joints.shoulder_angle == '0 && joints.elbow_angle == '0 &&
       joints.wrist_angle == '0))
    else $error("unsolved beat with nonzero angle");

  // input is held off only by a blocked result
  assert property (@(posedge clk) disable iff (rst)
    !target.ready |-> (joints.valid && !joints.ready))
    else $error("target stalled without output backpressure");

  // reset empties the output
  assert property (@(posedge clk) rst |=> !joints.valid)
    else $error("joints valid right after reset");

endmodule

// ===== rtl/pik_isqrt.sv =====
module pik_isqrt #(
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_valid,
  input  logic [63:0]      in_rad,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [31:0]      out_root,
  output logic [TAG_W-1:0] out_tag
);

  localparam int STEPS = 32;

  logic [63:0]      rem  [0:STEPS-1];
  logic [63:0]      root [0:STEPS-1];
  logic             vld  [0:STEPS-1];
  logic [TAG_W-1:0] tag  [0:STEPS-1];

  // one result bit per stage
  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic [63:0]      cr;
    logic [63:0]      cq;
    logic             cv;
    logic [TAG_W-1:0] ct;
    logic [63:0]      trial;

    if (j == 0) begin : g_first
      assign cr = in_rad;
      assign cq = '0;
      assign cv = in_valid;
      assign ct = in_tag;
    end else begin : g_next
      assign cr = rem[j-1];
      assign cq = root[j-1];
      assign cv = vld[j-1];
      assign ct = tag[j-1];
    end

    assign trial = cq + BIT;

    always_ff @(posedge clk) begin
      if (adv) begin
        if (cr >= trial) begin
          rem[j]  <= cr - trial;
          root[j] <= (cq >> 1) + BIT;
        end else begin
          rem[j]  <= cr;
          root[j] <= cq >> 1;
        end
        tag[j] <= ct;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (adv) begin
        vld[j] <= cv;
      end
    end
  end

  assign out_valid = vld[STEPS-1];
  assign out_root  = root[STEPS-1][31:0];
  assign out_tag   = tag[STEPS-1];

endmodule

// ===== rtl/pik_vector.sv =====
module pik_vector #(
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16,
  parameter int TAG_W         = 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                in_valid,
  input  logic signed [pik_pkg::VIN_W-1:0]    in_x,
  input  logic signed [pik_pkg::VIN_W-1:0]    in_y,
  input  logic [TAG_W-1:0]                    in_tag,
  output logic                                out_valid,
  output logic [ANGLE_BITS-1:0]               out_angle,
  output logic [TAG_W-1:0]                    out_tag
);

  localparam int AB = ANGLE_BITS;
  localparam int CS = CORDIC_STAGES;
  localparam int IW = pik_pkg::VIN_W;
  localparam int XW = pik_pkg::VEC_W;
  localparam int SW = pik_pkg::SUM_W;

  // half-plane fold
  logic signed [IW-1:0] ax, ay;
  logic                 aneg, azero, av;
  logic [TAG_W-1:0]     atag;

  always_ff @(posedge clk) begin
    if (adv) begin
      aneg  <= in_x < 0;
      azero <= (in_x == '0) && (in_y == '0);
      ax    <= (in_x < 0) ? -in_x : in_x;
      ay    <= (in_x < 0) ? -in_y : in_y;
      atag  <= in_tag;
    end
  end

  // larger magnitude
  logic signed [IW-1:0] ymag;
  logic signed [IW-1:0] bx, by;
  logic [IW-1:0]        bm;
  logic                 bneg, bzero, bv;
  logic [TAG_W-1:0]     btag;

  assign ymag = ay[IW-1] ? -ay : ay;

  always_ff @(posedge clk) begin
    if (adv) begin
      bm    <= (ax > ymag) ? ax : ymag;
      bx    <= ax;
      by    <= ay;
      bneg  <= aneg;
      bzero <= azero;
      btag  <= atag;
    end
  end

  // leading one position
  logic signed [IW-1:0] px, py;
  logic [5:0]           ppos;
  logic                 pneg, pzero, pv;
  logic [TAG_W-1:0]     ptag;

  always_ff @(posedge clk) begin
    if (adv) begin
      ppos  <= pik_pkg::msb_index(SW'(bm));
      px    <= bx;
      py    <= by;
      pneg  <= bneg;
      pzero <= bzero;
      ptag  <= btag;
    end
  end

  // cordic datapath, index 0 is the normalized operand pair
  logic signed [XW-1:0] cx    [0:CS];
  logic signed [XW-1:0] cy    [0:CS];
  logic [AB-1:0]        cz    [0:CS];
  logic                 czero [0:CS];
  logic                 cv    [0:CS];
  logic [TAG_W-1:0]     ctag  [0:CS];
  logic [5:0]           lsh;

  assign lsh = 6'd40 - ppos;

  always_ff @(posedge clk) begin
    if (adv) begin
      cx[0]    <= XW'(px) <<< lsh;
      cy[0]    <= XW'(py) <<< lsh;
      cz[0]    <= {pneg, {(AB-1){1'b0}}};
      czero[0] <= pzero;
      ctag[0]  <= ptag;
    end
  end

  // valid bits of the prescale stages
  always_ff @(posedge clk) begin
    if (rst) begin
      av    <= 1'b0;
      bv    <= 1'b0;
      pv    <= 1'b0;
      cv[0] <= 1'b0;
    end else if (adv) begin
      av    <= in_valid;
      bv    <= av;
      pv    <= bv;
      cv[0] <= pv;
    end
  end

  // vectoring iterations drive y toward zero
  for (genvar i = 0; i < CS; i++) begin : g_iter
    localparam logic [AB-1:0] A = AB'(pik_pkg::atan_q(i, AB));

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!cy[i][XW-1]) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + A;
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - A;
        end
        czero[i+1] <= czero[i];
        ctag[i+1]  <= ctag[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else if (adv) begin
        cv[i+1] <= cv[i];
      end
    end
  end

  assign out_valid = cv[CS];
  assign out_angle = czero[CS] ? '0 : cz[CS];
  assign out_tag   = ctag[CS];

endmodule

// ===== test/tb_planar_three_link_inverse_kinematics_top.sv =====
module tb_planar_three_link_inverse_kinematics_top;

  localparam int STAGES = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 90;
  localparam logic [pik_pkg::REG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic signed [pik_pkg::ANGLE_W-1:0] shoulder;
    logic signed [pik_pkg::ANGLE_W-1:0] elbow;
    logic signed [pik_pkg::ANGLE_W-1:0] wrist;
    pik_pkg::status_t status;
  } joint_res_t;

  // one directed row: either a register write or a target beat
  typedef struct {
    bit is_write;
    logic [pik_pkg::REG_IDX_W-1:0] idx;
    logic [pik_pkg::LINK_W-1:0] data;
    int x;
    int y;
    int ang;
    bit typed;
    pik_pkg::status_t status;
  } row_t;

  logic clk;
  logic rst;

  pik_target_if tgt();
  pik_joint_if jnt();
  pik_cfg_if cfg_bus();

  planar_three_link_inverse_kinematics_top dut (
    .clk(clk),
    .rst(rst),
    .target(tgt),
    .joints(jnt),
    .cfg(cfg_bus)
  );

  // mirrored link registers
  longint upper_len;
  longint fore_len;
  longint tool_len;

  joint_res_t joints_pending[$];
  int errors = 0;
  int accepted_targets;
  int checked_joints = 0;
  int send_idle;
  int recv_idle;
  bit pressure_go;
  int hold_left;
  int quiet_cycles = 0;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic logic [31:0] round_angle(logic [31:0] a);
    return (a + 32'h8000) & 32'hFFFF0000;
  endfunction

  function automatic logic [pik_pkg::ANGLE_W-1:0] to_counts(logic [31:0] a);
    logic [31:0] r;
    r = a + 32'h8000;
    return r[31:16];
  endfunction

  function automatic int shift_to_window(longint m);
    int sh;
    sh = 0;
    while (m >= (64'sd1 <<< 30)) begin
      m = m >>> 1;
      sh--;
    end
    while (m < (64'sd1 <<< 29)) begin
      m = m <<< 1;
      sh++;
    end
    return sh;
  endfunction

  function automatic longint apply_shift(longint v, int sh);
    if (sh >= 0) return v <<< sh;
    return v >>> (-sh);
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint absval(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // vectoring cordic bearing of (x, y)
  function automatic logic [31:0] bearing(longint y, longint x);
    logic [31:0] z;
    longint m;
    longint xs;
    longint ys;
    z = '0;
    if (x == 0 && y == 0) return z;
    m = (absval(x) > absval(y)) ? absval(x) : absval(y);
    while (m >= (64'sd1 <<< 41)) begin
      m = m >>> 1;
      x = x >>> 1;
      y = y >>> 1;
    end
    while (m < (64'sd1 <<< 40)) begin
      m = m <<< 1;
      x = x * 2;
      y = y * 2;
    end
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    for (int i = 0; i < STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + round_angle(pik_pkg::ATAN_TAB[i]);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - round_angle(pik_pkg::ATAN_TAB[i]);
      end
    end
    return z;
  endfunction

  // joint angles for one target under the mirrored link lengths
  function automatic joint_res_t solve_joints(longint tx, longint ty, logic [15:0] ang);
    joint_res_t r;
    logic [31:0] phi;
    logic [31:0] z;
    logic [31:0] elbow;
    logic [31:0] shoulder;
    longint unsigned prod;
    longint vx, vy, xs, ys, nx, ny, l1, l2, d, num, den, p, dn, nn, pp, s;
    int sh;
    r = '{shoulder: '0, elbow: '0, wrist: '0, status: pik_pkg::ST_SOLVED};
    phi = round_angle({ang, 16'h0});
    z = phi;
    prod = longint'(tool_len) * longint'(pik_pkg::INV_GAIN);
    vx = longint'(prod >> 15);
    vy = 0;
    if (z[31:30] == 2'd1 || z[31:30] == 2'd2) begin
      vx = -vx;
      z = z + 32'h80000000;
    end
    // rotate the tool vector to the tool angle
    for (int i = 0; i < STAGES; i++) begin
      xs = vx >>> i;
      ys = vy >>> i;
      if (!z[31]) begin
        vx = vx - ys;
        vy = vy + xs;
        z = z - round_angle(pik_pkg::ATAN_TAB[i]);
      end else begin
        vx = vx + ys;
        vy = vy - xs;
        z = z + round_angle(pik_pkg::ATAN_TAB[i]);
      end
    end
    nx = (tx * 65536 - vx + 8192) >>> 14;
    ny = (ty * 65536 - vy + 8192) >>> 14;
    l1 = upper_len * 4;
    l2 = fore_len * 4;
    d = nx * nx + ny * ny;
    num = d - l1 * l1 - l2 * l2;
    den = 2 * l1 * l2;
    p = d + l1 * l1 - l2 * l2;
    if (den == 0 || absval(num) > den) begin
      r.status = pik_pkg::ST_OUT_OF_REACH;
      return r;
    end
    if (d == 0) begin
      r.status = pik_pkg::ST_WRIST_AT_BASE;
      return r;
    end
    // elbow from the law of cosines
    sh = shift_to_window(den);
    dn = apply_shift(den, sh);
    nn = apply_shift(num, sh);
    if (nn > dn) nn = dn;
    if (nn < -dn) nn = -dn;
    s = floor_sqrt(longint'(dn - nn) * longint'(dn + nn));
    elbow = bearing(s, nn);
    // shoulder from the wrist bearing less the inner triangle angle
    sh = shift_to_window((den > absval(p)) ? den : absval(p));
    dn = apply_shift(den, sh);
    nn = apply_shift(num, sh);
    pp = apply_shift(p, sh);
    if (nn > dn) nn = dn;
    if (nn < -dn) nn = -dn;
    s = floor_sqrt(longint'(dn - nn) * longint'(dn + nn));
    shoulder = bearing(ny, nx) - bearing(s, pp);
    r.shoulder = to_counts(shoulder);
    r.elbow = to_counts(elbow);
    r.wrist = to_counts(phi - shoulder - elbow);
    return r;
  endfunction

  // offer one target beat, optionally idling first
  task automatic send_target(int x, int y, int ang, bit typed, pik_pkg::status_t st);
    joint_res_t e;
    cfg_bus.valid <= 1'b0;
    if ($urandom_range(99) < send_idle) begin
      tgt.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    tgt.valid <= 1'b1;
    tgt.target_x <= x[pik_pkg::COORD_W-1:0];
    tgt.target_y <= y[pik_pkg::COORD_W-1:0];
    tgt.tool_angle <= ang[pik_pkg::ANGLE_W-1:0];
    do @(posedge clk); while (!tgt.ready);
    if (typed) e = '{shoulder: '0, elbow: '0, wrist: '0, status: st};
    else e = solve_joints(x, y, ang[15:0]);
    joints_pending.push_back(e);
    accepted_targets++;
  endtask

  // let the pipeline run empty before touching the link registers
  task automatic drain();
    tgt.valid <= 1'b0;
    while (joints_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [pik_pkg::REG_IDX_W-1:0] idx,
                           logic [pik_pkg::LINK_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      pik_pkg::REG_UPPER: upper_len = data;
      pik_pkg::REG_FORE:  fore_len = data;
      pik_pkg::REG_TOOL:  tool_len = data;
      default: ;
    endcase
  endtask

  task automatic set_links(logic [pik_pkg::LINK_W-1:0] u, logic [pik_pkg::LINK_W-1:0] f,
                           logic [pik_pkg::LINK_W-1:0] t);
    drain();
    write_reg(pik_pkg::REG_UPPER, u);
    write_reg(pik_pkg::REG_FORE, f);
    write_reg(pik_pkg::REG_TOOL, t);
  endtask

  function automatic int clip_coord(longint v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return int'(v);
  endfunction

  // receiver side ready, with one long hold-off once requested
  always @(posedge clk) begin
    if (rst) begin
      jnt.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else if (pressure_go && hold_left > 0) begin
      jnt.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      jnt.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // joint beat checker and watchdog
  always @(posedge clk) begin
    joint_res_t e;
    if (!rst) begin
      if ((tgt.valid && tgt.ready) || (jnt.valid && jnt.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 joints_pending.size());
        $display("Some tests failed");
        $finish;
      end
      if (jnt.valid && jnt.ready) begin
        checked_joints++;
        if (joints_pending.size() == 0) begin
          $display("%0t: unexpected joint beat, actual %0d %0d %0d status %0d", $time,
                   jnt.shoulder_angle, jnt.elbow_angle, jnt.wrist_angle, jnt.solve_status);
          errors++;
        end else begin
          e = joints_pending.pop_front();
          if (jnt.shoulder_angle !== e.shoulder) begin
            $display("%0t: shoulder expected %0d actual %0d", $time, e.shoulder,
                     jnt.shoulder_angle);
            errors++;
          end
          if (jnt.elbow_angle !== e.elbow) begin
            $display("%0t: elbow expected %0d actual %0d", $time, e.elbow, jnt.elbow_angle);
            errors++;
          end
          if (jnt.wrist_angle !== e.wrist) begin
            $display("%0t: wrist expected %0d actual %0d", $time, e.wrist, jnt.wrist_angle);
            errors++;
          end
          if (jnt.solve_status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status,
                     jnt.solve_status);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    logic [pik_pkg::LINK_W-1:0] phase_links [RANDOM_PHASES][3];
    longint reach;
    int n;
    int x;
    int y;

    accepted_targets = 0;
    send_idle = 15;
    recv_idle = 82;
    pressure_go = 1'b0;
    upper_len = pik_pkg::UPPER_RESET;
    fore_len = pik_pkg::FORE_RESET;
    tool_len = pik_pkg::TOOL_RESET;
    rst = 1'b1;
    tgt.valid = 1'b0;
    tgt.target_x = '0;
    tgt.target_y = '0;
    tgt.tool_angle = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = pik_pkg::REG_UPPER;
    cfg_bus.data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed rows, reset link lengths first
    rows.push_back('{0, pik_pkg::REG_UPPER, 0, 0, 0, 0, 0, pik_pkg::ST_SOLVED});
    rows.push_back('{0, pik_pkg::REG_UPPER, 0, 131071, 131071, 0, 1,
                     pik_pkg::ST_OUT_OF_REACH});
    rows.push_back('{0, pik_pkg::REG_UPPER, 0, -131072, -131072, -32768, 1,
                     pik_pkg::ST_OUT_OF_REACH});
    rows.push_back('{0, pik_pkg::REG_UPPER, 0, 16384, 16384, 16384, 0, pik_pkg::ST_SOLVED});
    rows.push_back('{0, pik_pkg::REG_UPPER, 0, -20000, 5000, -16384, 0, pik_pkg::ST_SOLVED});
    rows.push_back('{0, pik_pkg::REG_UPPER, 0, 0, 20000, 32767, 0, pik_pkg::ST_SOLVED});
    rows.push_back('{0, pik_pkg::REG_UPPER, 0, 27000, 0, 0, 0, pik_pkg::ST_SOLVED});
    // arm fully stretched
    rows.push_back('{0, pik_pkg::REG_UPPER, 0, 36864, 0, 0, 0, pik_pkg::ST_SOLVED});
    // no tool link: wrist lands on the base
    rows.push_back('{1, pik_pkg::REG_TOOL, 0, 0, 0, 0, 0, pik_pkg::ST_SOLVED});
    rows.push_back('{0, pik_pkg::REG_UPPER, 0, 0, 0, 0, 1, pik_pkg::ST_WRIST_AT_BASE});
    rows.push_back('{0, pik_pkg::REG_UPPER, 0, 0, 0, 12345, 1, pik_pkg::ST_WRIST_AT_BASE});
    // zero upper link
    rows.push_back('{1, pik_pkg::REG_UPPER, 0, 0, 0, 0, 0, pik_pkg::ST_SOLVED});
    rows.push_back('{0, pik_pkg::REG_UPPER, 0, 1000, 1000, 0, 1, pik_pkg::ST_OUT_OF_REACH});
    // unequal links, elbow folded back
    rows.push_back('{1, pik_pkg::REG_UPPER, 16384, 0, 0, 0, 0, pik_pkg::ST_SOLVED});
    rows.push_back('{1, pik_pkg::REG_FORE, 8192, 0, 0, 0, 0, pik_pkg::ST_SOLVED});
    rows.push_back('{1, pik_pkg::REG_TOOL, 4096, 0, 0, 0, 0, pik_pkg::ST_SOLVED});
    rows.push_back('{0, pik_pkg::REG_UPPER, 0, 12288, 0, 0, 0, pik_pkg::ST_SOLVED});
    rows.push_back('{0, pik_pkg::REG_UPPER, 0, -12288, 0, -32768, 0, pik_pkg::ST_SOLVED});
    // write to the spare index changes nothing
    rows.push_back('{1, REG_SPARE, 16'hFFFF, 0, 0, 0, 0, pik_pkg::ST_SOLVED});
    rows.push_back('{0, pik_pkg::REG_UPPER, 0, 5000, -9000, 700, 0, pik_pkg::ST_SOLVED});
    // longest links
    rows.push_back('{1, pik_pkg::REG_UPPER, 16'hFFFF, 0, 0, 0, 0, pik_pkg::ST_SOLVED});
    rows.push_back('{1, pik_pkg::REG_FORE, 16'hFFFF, 0, 0, 0, 0, pik_pkg::ST_SOLVED});
    rows.push_back('{1, pik_pkg::REG_TOOL, 16'hFFFF, 0, 0, 0, 0, pik_pkg::ST_SOLVED});
    rows.push_back('{0, pik_pkg::REG_UPPER, 0, 131071, 0, 0, 0, pik_pkg::ST_SOLVED});
    rows.push_back('{0, pik_pkg::REG_UPPER, 0, -131072, 131071, 100, 0, pik_pkg::ST_SOLVED});

    foreach (rows[i]) begin
      if (rows[i].is_write) begin
        if (i == 0 || !rows[i-1].is_write) drain();
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        send_target(rows[i].x, rows[i].y, rows[i].ang, rows[i].typed, rows[i].status);
      end
    end

    // random phases, each under its own link lengths
    phase_links[0] = '{pik_pkg::UPPER_RESET, pik_pkg::FORE_RESET, pik_pkg::TOOL_RESET};
    phase_links[1] = '{16'hFFFF, 16'hFFFF, 16'h0000};
    phase_links[2] = '{16'd1, 16'd1, 16'd1};
    phase_links[3] = '{16'd20000, 16'd12000, 16'd8000};
    phase_links[4] = '{16'($urandom), 16'($urandom), 16'($urandom)};
    phase_links[5] = '{16'd8000, 16'd30000, 16'hFFFF};
    n = 0;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_links(phase_links[ph][0], phase_links[ph][1], phase_links[ph][2]);
      reach = upper_len + fore_len + tool_len + 1;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (n == RANDOM_PHASES * ITEMS_PER_PHASE / 3) begin
          send_idle = 82;
          recv_idle = 15;
        end else if (n == 2 * RANDOM_PHASES * ITEMS_PER_PHASE / 3) begin
          send_idle = 0;
          recv_idle = 0;
          pressure_go = 1'b1;
        end
        // mostly targets within the reach on each axis, the rest anywhere in the field range
        if ($urandom_range(99) < 75) begin
          x = clip_coord(longint'($urandom_range(2 * reach)) - reach);
          y = clip_coord(longint'($urandom_range(2 * reach)) - reach);
        end else begin
          x = $urandom_range(262143) - 131072;
          y = $urandom_range(262143) - 131072;
        end
        send_target(x, y, $urandom_range(65535) - 32768, 0, pik_pkg::ST_SOLVED);
        n++;
      end
    end

    drain();
    $display("%0d targets accepted, %0d joint beats checked over %0d link settings",
             accepted_targets, checked_joints, RANDOM_PHASES + 5);
    $display("covered reach limits, wrist at base, folded elbow and a long output stall");
    if (errors == 0 && joints_pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pik_pkg.sv
rtl/pik_if.sv
rtl/pik_isqrt.sv
rtl/pik_vector.sv
rtl/planar_three_link_inverse_kinematics_top.sv
test/tb_planar_three_link_inverse_kinematics_top.sv
